// ===== design/kcs_pkg.sv =====
// Package with constants, types and states of the keyframe curve sampler.
`timescale 1ns / 1ps
package kcs_pkg;
    localparam int MAX_KEYS = 16;
    localparam int SLOT_BITS = $clog2(MAX_KEYS);
    localparam int CNT_BITS = SLOT_BITS + 1;

    localparam logic [1:0] MODE_CONST = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    localparam logic [1:0] ST_SAMPLE = 2'd0;
    localparam logic [1:0] ST_WRITTEN = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [16:0] T_ONE = 17'd65536;
    localparam logic [1:0] ADDR_KEY_COUNT = 2'd0;

    typedef struct packed {
        logic        func;
        logic [3:0]  slot;
        logic [16:0] key_time;
        logic signed [31:0] key_value;
        logic signed [31:0] in_tangent;
        logic signed [31:0] out_tangent;
        logic [1:0]  interp_mode;
        logic [16:0] sample_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH, S_SRCH_W, S_FETCH, S_FETCH_W, S_LOADA, S_LOADB,
        S_DIV, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5, S_MUL6, S_MUL7,
        S_MUL8, S_MUL9, S_DONE
    } state_t;

    typedef struct packed {
        logic search_init;
        logic search_step;
        logic load_a;
        logic load_b;
        logic div_init;
        logic div_step;
        logic [3:0] mul_phase;
        logic mul_go;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic at_end;
        logic first;
        logic empty;
        logic div_done;
    } stat_t;
endpackage

// ===== design/keyframe_curve_sampler.sv =====
// Top level of the keyframe curve sampler.
// A key write gives its result strobe in the cycle after it is taken; a sample runs
// through the slot-by-slot search and, where it falls between two keys, the divider.
// One item is worked at a time; busy stays high through a sample's result strobe.
// The receiver cannot stall results; each strobe lasts exactly one cycle.
// Reset clears key_count and the controller; key slots hold garbage until written.
`timescale 1ns / 1ps
module keyframe_curve_sampler (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  kcs_pkg::in_item_t item,
    output logic result_valid,
    output kcs_pkg::out_item_t result,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import kcs_pkg::*;

    logic [4:0] key_count_reg;
    logic ctrl_busy, go, wr_key, wr_done_reg;
    logic [1:0] wr_status_reg;
    logic signed [31:0] value;
    cmd_t cmd;
    stat_t st;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_KEY_COUNT) ? {27'd0, key_count_reg} : '0;
    assign go = start && !busy && item.func;
    assign wr_key = start && !busy && !item.func && item.interp_mode != MODE_INVALID
                    && (32'(item.slot) < MAX_KEYS);
    assign busy = ctrl_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
            wr_done_reg <= 1'b0;
            wr_status_reg <= ST_SAMPLE;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == ADDR_KEY_COUNT)
            begin
                key_count_reg <= pwdata[4:0];
            end
            wr_done_reg <= start && !busy && !item.func;
            wr_status_reg <= (item.interp_mode == MODE_INVALID) ? ST_REJECT : ST_WRITTEN;
        end
    end

    kcs_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .go_sample(go), .st(st), .cmd(cmd),
        .busy(ctrl_busy));
    kcs_datapath u_dp (.clk(clk), .rst_n(rst_n), .wr_key(wr_key), .item(item),
        .key_count(key_count_reg), .cmd(cmd), .st(st), .result(value));

    always_comb
    begin
        result_valid = wr_done_reg || cmd.finish;
        result.sample_value = cmd.finish ? value : '0;
        result.status = cmd.finish ? ST_SAMPLE : wr_status_reg;
    end
endmodule

// ===== design/kcs_ram.sv =====
// Generic RAM with one write port, one separate read port and registered read.
`timescale 1ns / 1ps
module kcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/kcs_ctrl.sv =====
// Controller state machine of the keyframe curve sampler.
`timescale 1ns / 1ps
module kcs_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic go_sample,
    input  kcs_pkg::stat_t st,
    output kcs_pkg::cmd_t cmd,
    output logic busy
);
    import kcs_pkg::*;
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (go_sample)
                begin
                    cmd.search_init = 1'b1;
                    state_next = S_SRCH_W;
                end
            end
            S_SRCH_W: state_next = S_SRCH;
            S_SRCH:
            begin
                if (st.empty || st.found || st.at_end)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                    state_next = S_SRCH_W;
                end
            end
            S_FETCH:
            begin
                cmd.load_b = 1'b1;
                if (st.empty || st.first || st.at_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FETCH_W;
                end
            end
            S_FETCH_W: state_next = S_LOADA;
            S_LOADA:
            begin
                cmd.load_a = 1'b1;
                cmd.div_init = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5, S_MUL6, S_MUL7, S_MUL8:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_phase = 4'(state_reg - S_MUL1);
                state_next = state_t'(state_reg + 5'd1);
            end
            S_MUL9:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_phase = 4'd8;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== design/kcs_datapath.sv =====
// Datapath: key tables, search pointer, divider and Hermite multiplier.
`timescale 1ns / 1ps
module kcs_datapath (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_key,
    input  kcs_pkg::in_item_t item,
    input  logic [4:0] key_count,
    input  kcs_pkg::cmd_t cmd,
    output kcs_pkg::stat_t st,
    output logic signed [31:0] result
);
    import kcs_pkg::*;

    logic [SLOT_BITS-1:0] ptr_reg, ptr_next, raddr;
    logic [CNT_BITS-1:0] n_reg;
    logic [16:0] ts_reg, wtime, rtime;
    logic [31:0] rval, rin, rout;
    logic [1:0] rmode;
    logic [16:0] tb_reg, ta_reg;
    logic signed [31:0] vb_reg, va_reg, inb_reg, outa_reg;
    logic [1:0] ma_reg;
    logic [CNT_BITS-1:0] idx_reg;
    logic first_reg;
    logic [32:0] rem_reg;
    logic [16:0] q_reg;
    logic [4:0] dcnt_reg;
    logic [16:0] span_reg;
    logic signed [18:0] u2_reg, u3_reg;
    logic signed [49:0] m0_reg, m1_reg;
    logic signed [83:0] acc_reg;
    logic signed [31:0] res_reg;

    assign wtime = (item.key_time > T_ONE) ? T_ONE : item.key_time;
    assign raddr = cmd.search_init ? '0 : ptr_next;

    kcs_ram #(.WIDTH(17), .DEPTH(MAX_KEYS)) u_time (.clk(clk), .we(wr_key),
        .waddr(item.slot[SLOT_BITS-1:0]), .wdata(wtime), .raddr(raddr), .rdata(rtime));
    kcs_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_val (.clk(clk), .we(wr_key),
        .waddr(item.slot[SLOT_BITS-1:0]), .wdata(item.key_value), .raddr(raddr),
        .rdata(rval));
    kcs_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_in (.clk(clk), .we(wr_key),
        .waddr(item.slot[SLOT_BITS-1:0]), .wdata(item.in_tangent), .raddr(raddr),
        .rdata(rin));
    kcs_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_out (.clk(clk), .we(wr_key),
        .waddr(item.slot[SLOT_BITS-1:0]), .wdata(item.out_tangent), .raddr(raddr),
        .rdata(rout));
    kcs_ram #(.WIDTH(2), .DEPTH(MAX_KEYS)) u_mode (.clk(clk), .we(wr_key),
        .waddr(item.slot[SLOT_BITS-1:0]), .wdata(item.interp_mode), .raddr(raddr),
        .rdata(rmode));

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.search_init)
        begin
            ptr_next = '0;
        end
        else if (cmd.search_step)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
        else if (cmd.load_b && !first_reg)
        begin
            ptr_next = ptr_reg - 1'b1;
        end
    end

    // Search status for key ptr_reg; idx_reg is its index with the extra bit.
    assign st.empty = (n_reg == '0);
    assign st.found = (rtime > ts_reg);
    assign st.at_end = !st.found && (idx_reg + 1'b1 == n_reg);
    assign st.first = first_reg;
    assign st.div_done = (dcnt_reg == 5'd0);

    logic [33:0] dtrial;
    logic [17:0] rel;
    assign rel = {1'b0, ts_reg} - {1'b0, ta_reg};
    assign dtrial = {rem_reg, 1'b0} - {17'd0, span_reg};

    // Multiplier operand selection, one product per phase.
    logic signed [33:0] ma, mb;
    logic signed [67:0] prod;
    logic signed [18:0] u1;
    assign u1 = {2'b00, q_reg};
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.mul_phase)
            4'd0: begin ma = 34'(u1); mb = 34'(u1); end
            4'd1: begin ma = 34'(u2_reg); mb = 34'(u1); end
            4'd2: begin ma = 34'(outa_reg); mb = 34'({1'b0, span_reg}); end
            4'd3: begin ma = 34'(inb_reg); mb = 34'({1'b0, span_reg}); end
            4'd4: begin ma = 34'(2 * u3_reg - 3 * u2_reg + 19'sd65536);
                        mb = 34'(va_reg); end
            4'd5: begin ma = 34'(u3_reg - 2 * u2_reg + u1); mb = 34'(m0_reg); end
            4'd6: begin ma = 34'(-2 * u3_reg + 3 * u2_reg); mb = 34'(vb_reg); end
            4'd7: begin ma = 34'(u3_reg - u2_reg); mb = 34'(m1_reg); end
            default: begin ma = 34'(vb_reg) - 34'(va_reg); mb = 34'(u1); end
        endcase
    end
    assign prod = ma * mb;

    function automatic logic signed [31:0] sat(input logic signed [83:0] x);
        if (x > 84'sh7FFFFFFF)
        begin
            return 32'sh7FFFFFFF;
        end
        if (x < -84'sh80000000)
        begin
            return -32'sh80000000;
        end
        return x[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            n_reg <= '0;
            idx_reg <= '0;
            first_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cmd.search_init)
            begin
                ts_reg <= (item.sample_time > T_ONE) ? T_ONE : item.sample_time;
                n_reg <= (key_count > 5'(MAX_KEYS)) ? CNT_BITS'(MAX_KEYS)
                                                     : CNT_BITS'(key_count);
                idx_reg <= '0;
                first_reg <= 1'b1;
            end
            else if (cmd.search_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                first_reg <= 1'b0;
            end
            if (cmd.load_b)
            begin
                tb_reg <= rtime;
                vb_reg <= rval;
                inb_reg <= rin;
                if (st.empty)
                begin
                    res_reg <= '0;
                end
                else if (first_reg || st.at_end)
                begin
                    res_reg <= rval;
                end
            end
            if (cmd.load_a)
            begin
                ta_reg <= rtime;
                va_reg <= rval;
                outa_reg <= rout;
                ma_reg <= rmode;
                span_reg <= tb_reg - rtime;
                q_reg <= '0;
                dcnt_reg <= 5'd17;
            end
            if (cmd.div_init)
            begin
                rem_reg <= 33'({1'b0, ts_reg} - {1'b0, rtime});
            end
            else if (cmd.div_step && dcnt_reg != 5'd0)
            begin
                // Restoring division of rel<<16 by span, remainder prescaled.
                dcnt_reg <= dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd17)
                begin
                    q_reg <= '0;
                    rem_reg <= 33'(rel);
                end
                else if (!dtrial[33])
                begin
                    rem_reg <= dtrial[32:0];
                    q_reg <= {q_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[31:0], 1'b0};
                    q_reg <= {q_reg[15:0], 1'b0};
                end
            end
            if (cmd.mul_go)
            begin
                case (cmd.mul_phase)
                    4'd0: u2_reg <= 19'(prod >>> 16);
                    4'd1: u3_reg <= 19'(prod >>> 16);
                    4'd2: m0_reg <= 50'(prod >>> 16);
                    4'd3: m1_reg <= 50'(prod >>> 16);
                    4'd4: acc_reg <= 84'(prod);
                    4'd5, 4'd6, 4'd7: acc_reg <= acc_reg + 84'(prod);
                    default:
                    begin
                        if (span_reg == '0 || ma_reg == MODE_CONST)
                        begin
                            res_reg <= va_reg;
                        end
                        else if (ma_reg == MODE_LINEAR)
                        begin
                            res_reg <= sat(84'(va_reg) + 84'(prod >>> 16));
                        end
                        else
                        begin
                            res_reg <= sat(acc_reg >>> 16);
                        end
                    end
                endcase
            end
        end
    end

    assign result = res_reg;
endmodule
